// File: sv/flow_counter_table_lfu_evict_assert.svh
// Assertion macros shared by the flow counter table RTL.
`ifndef FLOW_COUNTER_TABLE_LFU_EVICT_ASSERT_SVH
`define FLOW_COUNTER_TABLE_LFU_EVICT_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low.
`define FCT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_n is low.
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fct_pkg.sv
// Types, constants and helper functions of the flow counter table.
`default_nettype none

package fct_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CRC,
    ST_MOD,
    ST_BASE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    OC_HIT    = 2'd0,
    OC_INSERT = 2'd1,
    OC_EVICT  = 2'd2
  } outcome_t;

  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_SEED     = 32'd1;
  localparam logic [31:0] CNT_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CNT_ONE      = 32'd1;

  // One stored way: flow key and its packet counter.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [31:0] count;
  } way_rec_t;

  // Reflected CRC-32 over one byte, no final inversion.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Packet counter increment that skips zero and all ones.
  function automatic logic [31:0] count_inc(input logic [31:0] cnt);
    logic [31:0] c;
    c = cnt + 32'd1;
    if (c == CNT_ALL_ONES || c == 32'd0) begin
      c = CNT_ONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/fct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fct_ram #(
  parameter int WIDTH = 136,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/flow_counter_table_lfu_evict.sv
// Set-associative flow counter table with least-frequently-used eviction.
// Steps from accept to result: a CRC step per key byte, a bucket reduction (one step if
// NUM_BUCKETS is a power of two, else a multiply-based remainder), a base step, a way scan,
// decide, update. A new item is taken only after the last one has written its result; the
// update waits for a free result register. Reset: synchronous, active low; then a clearing
// pass zeroes the table, one way per cycle, with in_ready low.
`default_nettype none
`include "flow_counter_table_lfu_evict_assert.svh"

module flow_counter_table_lfu_evict #(
  parameter int NUM_BUCKETS = 65536,
  parameter int WAYS        = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic        in_is_tcp,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [15:0] out_bucket_index,
  output logic [31:0] out_evicted_src,
  output logic [31:0] out_evicted_dst,
  output logic [31:0] out_evicted_ports,
  output logic [7:0]  out_evicted_proto,
  output logic [31:0] out_evicted_count,
  output logic [31:0] out_evicted_sum,
  output logic [31:0] out_evicted_time
);

  import fct_pkg::*;

  // Table geometry. Way w of bucket b lives at address b * WAYS + w.
  localparam int TOTAL   = NUM_BUCKETS * WAYS;
  localparam int ADDR_W  = $clog2(TOTAL);
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int WIW     = $clog2(WAYS + 1);
  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam int REC_W   = $bits(way_rec_t);

  // Reciprocal of the bucket count, scaled so that it fills 32 bits.
  localparam int          RECIP_SH = 31 + BKT_W;
  localparam logic [31:0] RECIP_M  = 32'((64'd1 << RECIP_SH) / NUM_BUCKETS);

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TOTAL - 1);
  localparam logic [31:0]       NB_W     = 32'(NUM_BUCKETS);
  localparam logic [WIW-1:0]    WAYS_C   = WIW'(WAYS);

  // Sequencer and clearing pass.
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Captured key and timestamp of the beat being worked on.
  logic [31:0] key_src_r, key_src_nxt;
  logic [31:0] key_dst_r, key_dst_nxt;
  logic [31:0] key_ports_r, key_ports_nxt;
  logic [7:0]  key_proto_r, key_proto_nxt;
  logic [31:0] ts_r, ts_nxt;

  // Hash and bucket reduction.
  logic [31:0]      crc_r, crc_nxt;
  logic [3:0]       crc_cnt_r, crc_cnt_nxt;
  logic [1:0]       mod_cnt_r, mod_cnt_nxt;
  logic [31:0]      mod_acc_r, mod_acc_nxt;
  logic [BKT_W-1:0] bucket_r, bucket_nxt;
  logic [127:0]     key_bytes;
  logic [6:0]       byte_sel;
  logic [63:0]      mod_prod;
  logic [31:0]      bucket_ext;

  // Way scan bookkeeping.
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [WIW-1:0]    sc_r, sc_nxt;
  logic [WIW-1:0]    pw;
  logic              hit_f_r, hit_f_nxt;
  logic [WIW-1:0]    hit_w_r, hit_w_nxt;
  logic              cand_f_r, cand_f_nxt;
  logic              cand_match_r, cand_match_nxt;
  logic [WIW-1:0]    cand_w_r, cand_w_nxt;
  logic [31:0]       min_val_r, min_val_nxt;
  logic [WIW-1:0]    min_w_r, min_w_nxt;
  logic [WIW-1:0]    sel_w;
  logic [ADDR_W-1:0] sel_addr_r, sel_addr_nxt;
  outcome_t          op_r, op_nxt;
  logic              way_match;
  logic              way_empty;

  // Table RAM port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  way_rec_t          ram_wrec;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  way_rec_t          rd;

  // Result register; it frees the input side while a result waits.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_outcome_r, out_outcome_nxt;
  logic [15:0] out_bucket_r, out_bucket_nxt;
  logic [31:0] out_src_r, out_src_nxt;
  logic [31:0] out_dst_r, out_dst_nxt;
  logic [31:0] out_ports_r, out_ports_nxt;
  logic [7:0]  out_proto_r, out_proto_nxt;
  logic [31:0] out_count_r, out_count_nxt;
  logic [31:0] out_sum_r, out_sum_nxt;
  logic [31:0] out_time_r, out_time_nxt;

  fct_ram #(
    .WIDTH(REC_W),
    .DEPTH(TOTAL)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wrec),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The key as the CRC sees it: four words, most significant byte first.
  assign key_bytes  = {key_src_r, key_dst_r, key_ports_r, 24'd0, key_proto_r};
  assign byte_sel   = 7'd127 - {crc_cnt_r, 3'b000};
  assign bucket_ext = 32'(bucket_r);
  assign rd         = way_rec_t'(ram_rdata);
  assign pw         = sc_r - WIW'(1);

  // A way matches when all four key words agree; it is empty when its source is zero.
  assign way_match = (rd.src == key_src_r) && (rd.dst == key_dst_r) &&
                     (rd.ports == key_ports_r) && (rd.proto == key_proto_r);
  assign way_empty = (rd.src == 32'd0);

  // Hash times the scaled reciprocal; its top bits estimate the quotient by NUM_BUCKETS.
  assign mod_prod = {32'd0, crc_r} * {32'd0, RECIP_M};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_src_r     <= key_src_nxt;
    key_dst_r     <= key_dst_nxt;
    key_ports_r   <= key_ports_nxt;
    key_proto_r   <= key_proto_nxt;
    ts_r          <= ts_nxt;
    crc_r         <= crc_nxt;
    crc_cnt_r     <= crc_cnt_nxt;
    mod_cnt_r     <= mod_cnt_nxt;
    mod_acc_r     <= mod_acc_nxt;
    bucket_r      <= bucket_nxt;
    base_r        <= base_nxt;
    sc_r          <= sc_nxt;
    hit_f_r       <= hit_f_nxt;
    hit_w_r       <= hit_w_nxt;
    cand_f_r      <= cand_f_nxt;
    cand_match_r  <= cand_match_nxt;
    cand_w_r      <= cand_w_nxt;
    min_val_r     <= min_val_nxt;
    min_w_r       <= min_w_nxt;
    sel_addr_r    <= sel_addr_nxt;
    op_r          <= op_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_bucket_r  <= out_bucket_nxt;
    out_src_r     <= out_src_nxt;
    out_dst_r     <= out_dst_nxt;
    out_ports_r   <= out_ports_nxt;
    out_proto_r   <= out_proto_nxt;
    out_count_r   <= out_count_nxt;
    out_sum_r     <= out_sum_nxt;
    out_time_r    <= out_time_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    key_src_nxt     = key_src_r;
    key_dst_nxt     = key_dst_r;
    key_ports_nxt   = key_ports_r;
    key_proto_nxt   = key_proto_r;
    ts_nxt          = ts_r;
    crc_nxt         = crc_r;
    crc_cnt_nxt     = crc_cnt_r;
    mod_cnt_nxt     = mod_cnt_r;
    mod_acc_nxt     = mod_acc_r;
    bucket_nxt      = bucket_r;
    base_nxt        = base_r;
    sc_nxt          = sc_r;
    hit_f_nxt       = hit_f_r;
    hit_w_nxt       = hit_w_r;
    cand_f_nxt      = cand_f_r;
    cand_match_nxt  = cand_match_r;
    cand_w_nxt      = cand_w_r;
    min_val_nxt     = min_val_r;
    min_w_nxt       = min_w_r;
    sel_addr_nxt    = sel_addr_r;
    op_nxt          = op_r;
    sel_w           = min_w_r;
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_bucket_nxt  = out_bucket_r;
    out_src_nxt     = out_src_r;
    out_dst_nxt     = out_dst_r;
    out_ports_nxt   = out_ports_r;
    out_proto_nxt   = out_proto_r;
    out_count_nxt   = out_count_r;
    out_sum_nxt     = out_sum_r;
    out_time_nxt    = out_time_r;
    ram_we          = 1'b0;
    ram_waddr       = sel_addr_r;
    ram_wrec        = '0;
    ram_re          = 1'b0;
    ram_raddr       = base_r + ADDR_W'(sc_r);
    in_ready        = 1'b0;

    // The consumer takes the waiting result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Zero one way per cycle; a zero source address marks it empty.
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_src_nxt   = in_src_addr;
          key_dst_nxt   = in_dst_addr;
          key_ports_nxt = {in_src_port, in_dst_port};
          key_proto_nxt = in_is_tcp ? PROTO_TCP : PROTO_UDP;
          ts_nxt        = in_timestamp;
          crc_nxt       = CRC_SEED;
          crc_cnt_nxt   = '0;
          state_nxt     = ST_CRC;
        end
      end
      ST_CRC: begin
        // One key byte per cycle through the shared CRC step.
        crc_nxt     = crc_byte(crc_r, key_bytes[byte_sel -: 8]);
        crc_cnt_nxt = crc_cnt_r + 4'd1;
        if (crc_cnt_r == 4'd15) begin
          mod_cnt_nxt = '0;
          bucket_nxt  = '0;
          state_nxt   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (IS_POW2) begin
          bucket_nxt = crc_r[BKT_W-1:0];
          state_nxt  = ST_BASE;
        end else begin
          // Remainder in four steps: quotient estimate, multiply back, subtract, and one
          // correction, since the estimate is at most one below the true quotient.
          mod_cnt_nxt = mod_cnt_r + 2'd1;
          case (mod_cnt_r)
            2'd0: begin
              mod_acc_nxt = 32'(mod_prod >> RECIP_SH);
            end
            2'd1: begin
              mod_acc_nxt = mod_acc_r * NB_W;
            end
            2'd2: begin
              mod_acc_nxt = crc_r - mod_acc_r;
            end
            default: begin
              bucket_nxt = (mod_acc_r >= NB_W) ? BKT_W'(mod_acc_r - NB_W) :
                                                 mod_acc_r[BKT_W-1:0];
              state_nxt  = ST_BASE;
            end
          endcase
        end
      end
      ST_BASE: begin
        base_nxt   = ADDR_W'(32'(bucket_r) * WAYS);
        sc_nxt     = '0;
        hit_f_nxt  = 1'b0;
        cand_f_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        // Read way sc_r while the data of way sc_r - 1 is judged.
        if (sc_r < WAYS_C) begin
          ram_re = 1'b1;
        end
        if (sc_r != '0) begin
          // A hit on an occupied way wins over everything else.
          if (!way_empty && way_match && !hit_f_r) begin
            hit_f_nxt = 1'b1;
            hit_w_nxt = pw;
          end
          // In way order, the first way that holds the key or is empty is taken.
          if (!cand_f_r && (way_match || way_empty)) begin
            cand_f_nxt     = 1'b1;
            cand_w_nxt     = pw;
            cand_match_nxt = way_match;
          end
          // Lowest count, ties to the lowest way.
          if (pw == '0 || rd.count < min_val_r) begin
            min_val_nxt = rd.count;
            min_w_nxt   = pw;
          end
        end
        sc_nxt = sc_r + WIW'(1);
        if (sc_r == WAYS_C) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_f_r) begin
          sel_w  = hit_w_r;
          op_nxt = OC_HIT;
        end else if (cand_f_r) begin
          sel_w  = cand_w_r;
          op_nxt = cand_match_r ? OC_HIT : OC_INSERT;
        end else begin
          sel_w  = min_w_r;
          op_nxt = OC_EVICT;
        end
        // Read the chosen way again for its count or eviction record.
        sel_addr_nxt = base_r + ADDR_W'(sel_w);
        ram_re       = 1'b1;
        ram_raddr    = sel_addr_nxt;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        // Write back and load the result once the result register is free.
        if (!out_valid_r || out_ready) begin
          ram_we = 1'b1;
          if (op_r == OC_HIT) begin
            ram_wrec       = rd;
            ram_wrec.count = count_inc(rd.count);
          end else begin
            ram_wrec.src   = key_src_r;
            ram_wrec.dst   = key_dst_r;
            ram_wrec.ports = key_ports_r;
            ram_wrec.proto = key_proto_r;
            ram_wrec.count = CNT_ONE;
          end
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = op_r;
          out_bucket_nxt  = bucket_ext[15:0];
          if (op_r == OC_EVICT) begin
            out_src_nxt   = rd.src;
            out_dst_nxt   = rd.dst;
            out_ports_nxt = rd.ports;
            out_proto_nxt = rd.proto;
            out_count_nxt = rd.count;
            out_sum_nxt   = rd.src + rd.dst + rd.ports + 32'(rd.proto);
            out_time_nxt  = ts_r;
          end else begin
            out_src_nxt   = '0;
            out_dst_nxt   = '0;
            out_ports_nxt = '0;
            out_proto_nxt = '0;
            out_count_nxt = '0;
            out_sum_nxt   = '0;
            out_time_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_outcome       = out_outcome_r;
  assign out_bucket_index  = out_bucket_r;
  assign out_evicted_src   = out_src_r;
  assign out_evicted_dst   = out_dst_r;
  assign out_evicted_ports = out_ports_r;
  assign out_evicted_proto = out_proto_r;
  assign out_evicted_count = out_count_r;
  assign out_evicted_sum   = out_sum_r;
  assign out_evicted_time  = out_time_r;

  // An evicted way was written by an insertion, so its protocol is valid.
  `FCT_ASSERT_IMPL(a_evict_proto, out_valid_r && out_outcome_r == OC_EVICT,
    out_proto_r == PROTO_TCP || out_proto_r == PROTO_UDP, "evicted protocol not 6 or 17")
  // An occupied way never holds a count of zero or all ones.
  `FCT_ASSERT_IMPL(a_evict_count, out_valid_r && out_outcome_r == OC_EVICT,
    out_count_r != 32'd0 && out_count_r != CNT_ALL_ONES, "evicted count out of range")
  // Records other than evictions carry zero eviction fields.
  `FCT_ASSERT_IMPL(a_no_evict_zero, out_valid_r && out_outcome_r != OC_EVICT,
    out_src_r == 32'd0 && out_count_r == 32'd0 && out_time_r == 32'd0,
    "eviction fields set without eviction")
  // The clearing pass ends only after the last table address.
  `FCT_ASSERT_IMPL(a_clear_done, state_r == ST_IDLE && $past(state_r) == ST_CLEAR,
    $past(clr_cnt_r) == CLR_LAST, "clearing pass ended early")
  // An accepted beat keeps the block busy in the next cycle.
  `FCT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "ready while a beat is in work")

endmodule

`default_nettype wire

// File: sim/tb_flow_counter_table_lfu_evict.sv
// Self-checking testbench of the flow counter table with least-frequently-used eviction.
`timescale 1ns / 100ps

module tb_flow_counter_table_lfu_evict;
  import fct_pkg::*;

  localparam int BUCKETS = 65536;
  localparam int NWAYS = 5;
  localparam int RANDOM_ITEMS = 2000;
  localparam int GROUPS = 8;
  localparam int POOL = 8;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 64;
  // Slowest legal run: the clearing pass after reset, then every packet waiting out the
  // longest sender gap, the longest receiver stall and the block's own processing time, plus
  // the two long holds. The limit is that figure taken about three times over.
  localparam longint unsigned CYCLE_LIMIT = 64'd2_500_000;

  // One flow key as it arrives on the input ports.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        tcp;
  } flow_t;

  // One input beat waiting to be offered. A drain packet is held back until every result
  // of the packets before it has come out; burst packets are sent back to back.
  typedef struct {
    flow_t       flow;
    logic [31:0] stamp;
    bit          drain;
    bit          burst;
  } packet_t;

  // One result beat as the block should produce it.
  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] bucket;
    logic [31:0] e_src;
    logic [31:0] e_dst;
    logic [31:0] e_ports;
    logic [7:0]  e_proto;
    logic [31:0] e_count;
    logic [31:0] e_sum;
    logic [31:0] e_time;
  } record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic        in_is_tcp = 1'b0;
  logic [31:0] in_timestamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_outcome;
  logic [15:0] out_bucket_index;
  logic [31:0] out_evicted_src;
  logic [31:0] out_evicted_dst;
  logic [31:0] out_evicted_ports;
  logic [7:0]  out_evicted_proto;
  logic [31:0] out_evicted_count;
  logic [31:0] out_evicted_sum;
  logic [31:0] out_evicted_time;

  packet_t packet_queue[$];
  record_t due_records[$];
  packet_t cur_pkt;

  // Shadow copy of the way store. Entries never written read as zero, as after the
  // clearing pass of the block.
  way_rec_t flow_ways[int unsigned];

  int unsigned     accepted_total = 0;
  int unsigned     results_seen = 0;
  int unsigned     gap_left = 0;
  int unsigned     hold_left = 0;
  int unsigned     stall_left = 0;
  int              mismatches = 0;
  longint unsigned cycle_count = 0;

  // Elimination basis of the map from destination address bits to bucket bits. It lets
  // the stimulus steer any flow into a chosen bucket by flipping destination bits only.
  logic [15:0] basis_vec[16];
  logic [31:0] basis_mask[16];
  bit          basis_set[16];

  flow_counter_table_lfu_evict #(
    .NUM_BUCKETS(BUCKETS),
    .WAYS       (NWAYS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_is_tcp        (in_is_tcp),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_bucket_index (out_bucket_index),
    .out_evicted_src  (out_evicted_src),
    .out_evicted_dst  (out_evicted_dst),
    .out_evicted_ports(out_evicted_ports),
    .out_evicted_proto(out_evicted_proto),
    .out_evicted_count(out_evicted_count),
    .out_evicted_sum  (out_evicted_sum),
    .out_evicted_time (out_evicted_time)
  );

  always #2 clk = ~clk;

  // Reflected CRC-32 over one key word, most significant byte first, no final inversion.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] c;
    c = crc;
    for (int b = 3; b >= 0; b--) begin
      c = c ^ {24'd0, word[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] key_hash(input logic [31:0] seed, input logic [31:0] w0,
                                           input logic [31:0] w1, input logic [31:0] w2,
                                           input logic [31:0] w3);
    return crc_feed(crc_feed(crc_feed(crc_feed(seed, w0), w1), w2), w3);
  endfunction

  function automatic logic [7:0] flow_proto(input flow_t f);
    return f.tcp ? PROTO_TCP : PROTO_UDP;
  endfunction

  function automatic logic [15:0] flow_bucket(input flow_t f);
    logic [31:0] h;
    h = key_hash(CRC_SEED, f.src, f.dst, {f.sport, f.dport}, {24'd0, flow_proto(f)});
    return 16'(h % BUCKETS);
  endfunction

  // The hash is affine in the key, so the bucket change caused by flipping destination
  // bits does not depend on the rest of the key. The images are taken with a zero seed.
  task automatic build_dst_basis();
    logic [15:0] v;
    logic [31:0] m;
    bit          placed;
    for (int b = 0; b < 16; b++) begin
      basis_set[b] = 1'b0;
    end
    for (int i = 0; i < 32; i++) begin
      v = 16'(key_hash(32'd0, 32'd0, 32'd1 << i, 32'd0, 32'd0));
      m = 32'd1 << i;
      placed = 1'b0;
      for (int b = 15; b >= 0; b--) begin
        if (!placed && v[b]) begin
          if (basis_set[b]) begin
            v = v ^ basis_vec[b];
            m = m ^ basis_mask[b];
          end else begin
            basis_vec[b] = v;
            basis_mask[b] = m;
            basis_set[b] = 1'b1;
            placed = 1'b1;
          end
        end
      end
    end
  endtask

  // Moves a flow into the target bucket by flipping the destination bits that cancel the
  // difference. The bucket count is a power of two, so the bucket is the low hash bits.
  function automatic flow_t steer_flow(input flow_t f, input logic [15:0] target);
    logic [15:0] t;
    logic [31:0] m;
    t = flow_bucket(f) ^ target;
    m = 32'd0;
    for (int b = 15; b >= 0; b--) begin
      if (t[b] && basis_set[b]) begin
        t = t ^ basis_vec[b];
        m = m ^ basis_mask[b];
      end
    end
    f.dst = f.dst ^ m;
    return f;
  endfunction

  // A random flow; with zero_odds above zero, one in zero_odds gets source address zero.
  function automatic flow_t random_flow(input int zero_odds);
    flow_t f;
    f.src = $urandom;
    f.dst = $urandom;
    f.sport = 16'($urandom_range(0, 65535));
    f.dport = 16'($urandom_range(0, 65535));
    f.tcp = 1'($urandom_range(0, 1));
    if (zero_odds != 0 && $urandom_range(1, zero_odds) == 1) begin
      f.src = '0;
    end
    return f;
  endfunction

  // Idle length, never zero: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic way_rec_t read_way(input int unsigned idx);
    way_rec_t w;
    w = '0;
    if (flow_ways.exists(idx)) begin
      w = flow_ways[idx];
    end
    return w;
  endfunction

  // Counter step that skips zero and all ones.
  function automatic logic [31:0] bump_count(input logic [31:0] c);
    logic [31:0] n;
    n = c + 32'd1;
    if (n == 32'hFFFF_FFFF || n == 32'd0) begin
      n = 32'd1;
    end
    return n;
  endfunction

  function automatic bit same_flow(input way_rec_t a, input way_rec_t b);
    return {a.src, a.dst, a.ports, a.proto} == {b.src, b.dst, b.ports, b.proto};
  endfunction

  // Counts one accepted packet in the shadow store and queues the result it must cause.
  task automatic count_packet(input flow_t f, input logic [31:0] stamp);
    record_t     rec;
    way_rec_t    key;
    way_rec_t    way;
    logic [15:0] bucket;
    logic [31:0] min_count;
    int unsigned base;
    int unsigned min_way;
    bit          done;
    key.src = f.src;
    key.dst = f.dst;
    key.ports = {f.sport, f.dport};
    key.proto = flow_proto(f);
    key.count = CNT_ONE;
    bucket = flow_bucket(f);
    base = int'(bucket) * NWAYS;
    rec = '0;
    rec.outcome = OC_HIT;
    rec.bucket = bucket;
    done = 1'b0;
    // Ways whose source address is zero read as empty and are skipped by the search.
    for (int i = 0; i < NWAYS; i++) begin
      way = read_way(base + i);
      if (!done && way.src != '0 && same_flow(way, key)) begin
        way.count = bump_count(way.count);
        flow_ways[base + i] = way;
        done = 1'b1;
      end
    end
    // The ordered scan tests the exact key before emptiness, so a stored flow with a zero
    // source address is still counted when it recurs.
    min_way = 0;
    min_count = read_way(base).count;
    for (int i = 0; i < NWAYS; i++) begin
      way = read_way(base + i);
      if (!done) begin
        if (same_flow(way, key)) begin
          way.count = bump_count(way.count);
          flow_ways[base + i] = way;
          done = 1'b1;
        end else if (way.src == '0) begin
          flow_ways[base + i] = key;
          rec.outcome = OC_INSERT;
          done = 1'b1;
        end else if (way.count < min_count) begin
          min_count = way.count;
          min_way = i;
        end
      end
    end
    // Full bucket: the least counted way goes, the lowest one on a tie.
    if (!done) begin
      way = read_way(base + min_way);
      rec.outcome = OC_EVICT;
      rec.e_src = way.src;
      rec.e_dst = way.dst;
      rec.e_ports = way.ports;
      rec.e_proto = way.proto;
      rec.e_count = way.count;
      rec.e_sum = way.src + way.dst + way.ports + {24'd0, way.proto};
      rec.e_time = stamp;
      flow_ways[base + min_way] = key;
    end
    due_records.push_back(rec);
  endtask

  task automatic push_packet(input flow_t f, input logic [31:0] stamp, input bit drain,
                             input bit burst);
    packet_t pkt;
    pkt.flow = f;
    pkt.stamp = stamp;
    pkt.drain = drain;
    pkt.burst = burst;
    packet_queue.push_back(pkt);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Result beat %0d, %s: expected %h, got %h", results_seen, name, want, got);
      end
    end
  endtask

  // Input driver. The beat accepted at this edge is counted first, then the next one is
  // put on the ports. A drain packet waits until every accepted beat has its result.
  always @(posedge clk) begin : packet_driver
    packet_t     pkt;
    int unsigned gap;
    gap = gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        count_packet(cur_pkt.flow, cur_pkt.stamp);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (gap != 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (packet_queue.size() != 0 &&
                     !(packet_queue[0].drain && accepted_total != results_seen)) begin
          pkt = packet_queue.pop_front();
          cur_pkt = pkt;
          in_src_addr <= pkt.flow.src;
          in_dst_addr <= pkt.flow.dst;
          in_src_port <= pkt.flow.sport;
          in_dst_port <= pkt.flow.dport;
          in_is_tcp <= pkt.flow.tcp;
          in_timestamp <= pkt.stamp;
          in_valid <= 1'b1;
          // The gap is taken after this beat is accepted.
          gap = (pkt.burst || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    gap_left <= gap;
  end

  // Result monitor. Each accepted result beat is checked against the oldest due record.
  // Twice in the run the receiver holds off for a long stretch so that the block backs up
  // into its input; around results 600 to 800 it never stalls.
  always @(posedge clk) begin : result_monitor
    record_t     rec;
    int unsigned seen;
    int unsigned hold;
    int unsigned stall;
    seen = results_seen;
    hold = hold_left;
    stall = stall_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result beat %0d arrived with no packet waiting for it", seen);
          end
        end else begin
          rec = due_records.pop_front();
          check_field("outcome", {30'd0, rec.outcome}, {30'd0, out_outcome});
          check_field("bucket_index", {16'd0, rec.bucket}, {16'd0, out_bucket_index});
          check_field("evicted_src", rec.e_src, out_evicted_src);
          check_field("evicted_dst", rec.e_dst, out_evicted_dst);
          check_field("evicted_ports", rec.e_ports, out_evicted_ports);
          check_field("evicted_proto", {24'd0, rec.e_proto}, {24'd0, out_evicted_proto});
          check_field("evicted_count", rec.e_count, out_evicted_count);
          check_field("evicted_sum", rec.e_sum, out_evicted_sum);
          check_field("evicted_time", rec.e_time, out_evicted_time);
        end
        seen++;
        if (seen == 300 || seen == 1500) begin
          hold = RX_HOLD_CYCLES;
        end
      end
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (seen >= 600 && seen < 800) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    results_seen <= seen;
    hold_left <= hold;
    stall_left <= stall;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    flow_t       fa[7];
    flow_t       gb[9];
    flow_t       f;
    flow_t       pool[GROUPS][POOL];
    logic [15:0] target[GROUPS];
    int          r;
    int          g;
    int          p;

    build_dst_basis();

    // Top bucket with the largest field values: fill all five ways, count some flows up,
    // then two newcomers evict the lowest counted way, ties going to the lowest way.
    for (int i = 0; i < 7; i++) begin
      fa[i] = random_flow(0);
    end
    fa[0].src = '1;
    fa[0].sport = '1;
    fa[0].dport = '1;
    fa[0].tcp = 1'b1;
    for (int i = 0; i < 7; i++) begin
      fa[i] = steer_flow(fa[i], 16'hFFFF);
    end
    push_packet(fa[0], '1, 1'b0, 1'b0);
    for (int i = 1; i < 5; i++) begin
      push_packet(fa[i], $urandom, 1'b0, 1'b0);
    end
    push_packet(fa[2], $urandom, 1'b0, 1'b0);
    push_packet(fa[2], $urandom, 1'b0, 1'b0);
    push_packet(fa[0], $urandom, 1'b0, 1'b0);
    push_packet(fa[5], $urandom, 1'b0, 1'b0);
    push_packet(fa[6], $urandom, 1'b0, 1'b0);
    push_packet(fa[1], '0, 1'b0, 1'b0);

    // An all-zero key lands in whatever bucket it hashes to.
    f = '0;
    push_packet(f, '0, 1'b0, 1'b0);

    // Bucket zero and source address zero: such a flow is stored, counted when it recurs,
    // overwritten by the next insertion, and stored again over an evicted way.
    for (int i = 0; i < 9; i++) begin
      gb[i] = random_flow(0);
    end
    gb[0].src = '0;
    gb[0].sport = '0;
    gb[0].dport = '0;
    gb[0].tcp = 1'b0;
    gb[2].src = '0;
    gb[7].src = '0;
    for (int i = 0; i < 9; i++) begin
      gb[i] = steer_flow(gb[i], 16'h0000);
    end
    push_packet(gb[0], $urandom, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      push_packet(gb[i], $urandom, 1'b0, 1'b0);
    end

    // Random part: mostly packets of small flow pools that share one bucket each, so that
    // hits, insertions and evictions all keep happening, with some stray flows among them.
    for (int i = 0; i < GROUPS; i++) begin
      target[i] = 16'($urandom_range(0, 65535));
      for (int j = 0; j < POOL; j++) begin
        pool[i][j] = steer_flow(random_flow(10), target[i]);
      end
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        f = random_flow(16);
      end else begin
        g = $urandom_range(0, GROUPS - 1);
        // Half of the picks are drawn from the first three flows only, which builds up uneven counts.
        p = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(0, POOL - 1);
        if ($urandom_range(0, 49) == 0) begin
          pool[g][p] = steer_flow(random_flow(10), target[g]);
        end
        f = pool[g][p];
        if ($urandom_range(0, 299) == 0) begin
          r = $urandom_range(0, 9);
          target[g] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
          for (int j = 0; j < POOL; j++) begin
            pool[g][j] = steer_flow(random_flow(10), target[g]);
          end
        end
      end
      push_packet(f, $urandom, n == 0 || n == 1000, n >= 600 && n < 800);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (packet_queue.size() != 0 || in_valid) @(posedge clk);
    while (accepted_total != results_seen) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (due_records.size() != 0) begin
      mismatches += due_records.size();
      $display("%0d result beats never arrived", due_records.size());
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
